/* sv/anu_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Adaptive network update package
// Shared beat types, command and status codes, register map and sequencer
// state encodings for the adaptive network update step unit.
// ---------------------------------------------------------------------------
package anu_pkg;

	// Command codes carried in the func field.
	localparam logic [1:0] FUNC_EDGE   = 2'd0;
	localparam logic [1:0] FUNC_LEVEL  = 2'd1;
	localparam logic [1:0] FUNC_UPDATE = 2'd2;
	localparam logic [1:0] FUNC_COUNT  = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_ISOLATED = 2'd1;
	localparam logic [1:0] ST_ACK      = 2'd2;
	localparam logic [1:0] ST_COUNT    = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_REWIRE    = 3'd0;
	localparam logic [2:0] REG_COPY      = 3'd1;
	localparam logic [2:0] REG_DROP_SAME = 3'd2;
	localparam logic [2:0] REG_ADD_SAME  = 3'd3;
	localparam logic [2:0] REG_TOL       = 3'd4;

	// Register reset values.
	localparam logic [15:0] RST_REWIRE    = 16'hFFFF;
	localparam logic [15:0] RST_COPY      = 16'h0000;
	localparam logic [15:0] RST_DROP_SAME = 16'h8000;
	localparam logic [15:0] RST_ADD_SAME  = 16'h8000;
	localparam logic [5:0]  RST_TOL       = 6'd0;

	// Largest discordant count that is reported.
	localparam logic [14:0] DISC_MAX = 15'h7FFF;

	// Input beat.
	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  node_a;
		logic [7:0]  node_b;
		logic [5:0]  value;
		logic [15:0] draw_rewire;
		logic [15:0] draw_drop_class;
		logic [31:0] pick_drop;
		logic [15:0] draw_add_class;
		logic [31:0] pick_add;
		logic [15:0] draw_copy;
		logic [31:0] pick_peer;
	} cmd_t;

	// Result beat.
	typedef struct packed {
		logic [1:0]  status;
		logic        rewired;
		logic [7:0]  dropped_node;
		logic [7:0]  added_node;
		logic        copied;
		logic [5:0]  new_level;
		logic [14:0] discordant_count;
	} rsp_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ROW_RD,
		S_ROW_LAT,
		S_SCAN,
		S_POST,
		S_DIV,
		S_RMW_RD,
		S_RMW_WR,
		S_CHK,
		S_COPY,
		S_DONE
	} state_t;

	// What a row scan gathers.
	typedef enum logic [1:0] {
		M_CNT,
		M_FIND,
		M_PEER,
		M_DISC
	} scan_mode_t;

	// Where a remainder from the divider goes.
	typedef enum logic [1:0] {
		D_DROP,
		D_ADD,
		D_PEER
	} div_tgt_t;

endpackage

/* sv/adaptive_network_update_step_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Adaptive network update step unit
// Adjacency bit matrix and node levels held in two synchronous memories,
// worked on by a sequencer that scans one node per cycle.
// ---------------------------------------------------------------------------
// A valid edge write takes two read-modify-writes and a level write one memory write; an
// update runs up to three row scans, up to three remainder divisions and four
// read-modify-writes when rewiring and copying; a count query reads the matrix
// one bit per cycle within each row scan, row by row above the diagonal.
// The pace is set by the single read port of each memory. One item at a time.
// After reset both memories are cleared word by word before the first command is taken.
// Results are strobed for one cycle; the receiver cannot stall them.
module adaptive_network_update_step_unit #(
	parameter int NODES  = 256,
	parameter int LEVELS = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  anu_pkg::cmd_t cmd,
	output logic          done,
	output anu_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int WPR       = (NODES + 63) / 64;
	localparam int ADJ_DEPTH = NODES * WPR;
	localparam int AW        = $clog2(ADJ_DEPTH);
	localparam int LW        = $clog2(NODES);
	localparam int CW        = $clog2(NODES + 1);
	localparam int XW        = CW + 6;

	// Configuration registers.
	logic [15:0] rewire_q, copy_q, drop_same_q, add_same_q;
	logic [5:0]  tol_q;

	// Sequencer registers.
	anu_pkg::state_t     state_q, state_d;
	anu_pkg::scan_mode_t mode_q;
	anu_pkg::div_tgt_t   tgt_q;
	anu_pkg::cmd_t       cmd_q;
	anu_pkg::rsp_t       res_q;
	logic                done_q;
	logic [AW-1:0]       clr_q;
	logic [LW-1:0]       row_q, a_q, dn_q, an_q;
	logic [CW-1:0]       j_q, j_s1;
	logic                v_s1;
	logic [5:0]          lvl_ref_q, peer_lv_q;
	logic [CW-1:0]       c_deg_q, c_drop_q, c_add_q;
	logic [CW-1:0]       seen_d_q, seen_a_q, k_d_q, k_a_q;
	logic                found_d_q, found_a_q;
	logic [14:0]         disc_q;
	logic [1:0]          op_q;
	logic [4:0]          div_cnt_q;
	logic [31:0]         div_num_q;
	logic [CW-1:0]       div_den_q, div_rem_q;

	// Memories and their ports.
	logic [63:0]   adj_mem [ADJ_DEPTH];
	logic [5:0]    lvl_mem [NODES];
	logic [AW-1:0] adj_raddr, adj_waddr;
	logic [63:0]   adj_rdata, adj_wdata;
	logic          adj_we;
	logic [LW-1:0] lvl_raddr, lvl_waddr;
	logic [5:0]    lvl_rdata, lvl_wdata;
	logic          lvl_we;

	// Word address of matrix bit (r, c) with rows padded to whole words.
	function automatic logic [AW-1:0] adj_addr(input logic [LW-1:0] r,
		input logic [CW-1:0] c);
		logic [XW-1:0] cx;
		cx = XW'(c);
		return AW'(int'(r) * WPR + int'(cx[XW-1:6]));
	endfunction

	// Bit position of column c within its word.
	function automatic logic [5:0] adj_col(input logic [CW-1:0] c);
		logic [XW-1:0] cx;
		cx = XW'(c);
		return cx[5:0];
	endfunction

	// Decoded command conditions.
	logic rewire_go, copy_go, drop_same, add_same;
	assign rewire_go = cmd_q.draw_rewire <= rewire_q;
	assign copy_go   = cmd_q.draw_copy <= copy_q;
	assign drop_same = cmd_q.draw_drop_class <= drop_same_q;
	assign add_same  = cmd_q.draw_add_class <= add_same_q;

	logic accept;
	assign accept = start && !busy;

	// Scan issue and first-stage evaluation.
	logic          issuing, scan_end, bit_s1, ne_s1, same_s1;
	assign issuing  = (state_q == anu_pkg::S_SCAN) && (j_q < CW'(NODES));
	assign scan_end = (state_q == anu_pkg::S_SCAN) && !issuing && !v_s1;
	assign bit_s1   = adj_rdata[adj_col(j_s1)];
	assign ne_s1    = j_s1 != CW'(row_q);
	assign same_s1  = lvl_rdata == lvl_ref_q;

	// Read-modify-write operand selection.
	logic [LW-1:0] x_node, op_row, op_col;
	logic          op_val, op_last;
	assign x_node = (cmd_q.func == anu_pkg::FUNC_EDGE) ? LW'(cmd_q.node_b) : dn_q;
	always_comb begin
		case (op_q)
			2'd0:    begin op_row = a_q;    op_col = x_node; end
			2'd1:    begin op_row = x_node; op_col = a_q;    end
			2'd2:    begin op_row = a_q;    op_col = an_q;   end
			default: begin op_row = an_q;   op_col = a_q;    end
		endcase
	end
	assign op_val  = op_q[1] ? 1'b1 :
		((cmd_q.func == anu_pkg::FUNC_EDGE) ? cmd_q.value[0] : 1'b0);
	assign op_last = (cmd_q.func == anu_pkg::FUNC_EDGE) ? (op_q == 2'd1) : (op_q == 2'd3);

	// One restoring remainder step.
	logic [CW:0]   div_trial;
	logic [CW-1:0] div_rem_d;
	assign div_trial = {div_rem_q, div_num_q[31]};
	assign div_rem_d = (div_trial >= {1'b0, div_den_q}) ?
		CW'(div_trial - {1'b0, div_den_q}) : CW'(div_trial);

	// Level difference for the copy decision.
	logic [5:0] lvl_diff;
	assign lvl_diff = (lvl_ref_q > peer_lv_q) ? (lvl_ref_q - peer_lv_q) : (peer_lv_q - lvl_ref_q);

	// Saturated level for level writes.
	logic [5:0] lvl_sat;
	assign lvl_sat = (32'(cmd.value) >= LEVELS) ? 6'(LEVELS - 1) : cmd.value;

	// Memory arrays.
	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
		adj_rdata <= adj_mem[adj_raddr];
	end

	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
		lvl_rdata <= lvl_mem[lvl_raddr];
	end

	// Next state and memory port control.
	always_comb begin
		state_d   = state_q;
		adj_raddr = adj_addr(row_q, j_q);
		adj_waddr = adj_addr(op_row, CW'(op_col));
		adj_wdata = (adj_rdata & ~(64'd1 << adj_col(CW'(op_col))))
			| ({63'd0, op_val} << adj_col(CW'(op_col)));
		adj_we    = 1'b0;
		lvl_raddr = j_q[LW-1:0];
		lvl_waddr = a_q;
		lvl_wdata = peer_lv_q;
		lvl_we    = 1'b0;
		unique case (state_q)
			anu_pkg::S_CLEAR: begin
				adj_waddr = clr_q;
				adj_wdata = '0;
				adj_we    = 1'b1;
				lvl_waddr = clr_q[LW-1:0];
				lvl_wdata = '0;
				lvl_we    = 32'(clr_q) < NODES;
				if (clr_q == AW'(ADJ_DEPTH - 1)) state_d = anu_pkg::S_IDLE;
			end
			anu_pkg::S_IDLE: begin
				if (accept) begin
					case (cmd.func)
						anu_pkg::FUNC_EDGE: begin
							if (32'(cmd.node_a) < NODES && 32'(cmd.node_b) < NODES
								&& cmd.node_a != cmd.node_b)
								state_d = anu_pkg::S_RMW_RD;
							else
								state_d = anu_pkg::S_DONE;
						end
						anu_pkg::FUNC_LEVEL: begin
							lvl_waddr = LW'(cmd.node_a);
							lvl_wdata = lvl_sat;
							lvl_we    = 32'(cmd.node_a) < NODES;
							state_d   = anu_pkg::S_DONE;
						end
						anu_pkg::FUNC_UPDATE: begin
							state_d = (32'(cmd.node_a) < NODES) ? anu_pkg::S_ROW_RD
								: anu_pkg::S_DONE;
						end
						default: state_d = anu_pkg::S_ROW_RD;
					endcase
				end
			end
			anu_pkg::S_ROW_RD: begin
				lvl_raddr = row_q;
				state_d   = anu_pkg::S_ROW_LAT;
			end
			anu_pkg::S_ROW_LAT: state_d = anu_pkg::S_SCAN;
			anu_pkg::S_SCAN: begin
				if (scan_end) begin
					case (mode_q)
						anu_pkg::M_CNT:  state_d = anu_pkg::S_POST;
						anu_pkg::M_FIND: state_d = anu_pkg::S_RMW_RD;
						anu_pkg::M_PEER: state_d = anu_pkg::S_COPY;
						default: begin
							state_d = (row_q == LW'(NODES - 1)) ? anu_pkg::S_DONE
								: anu_pkg::S_ROW_RD;
						end
					endcase
				end
			end
			anu_pkg::S_POST: begin
				if (c_deg_q == '0)
					state_d = anu_pkg::S_DONE;
				else if (rewire_go && c_drop_q != '0 && c_add_q != '0)
					state_d = anu_pkg::S_DIV;
				else
					state_d = anu_pkg::S_CHK;
			end
			anu_pkg::S_DIV: begin
				if (div_cnt_q == 5'd31 && tgt_q != anu_pkg::D_DROP) state_d = anu_pkg::S_SCAN;
			end
			anu_pkg::S_RMW_RD: begin
				adj_raddr = adj_waddr;
				state_d   = anu_pkg::S_RMW_WR;
			end
			anu_pkg::S_RMW_WR: begin
				adj_we = 1'b1;
				if (!op_last)
					state_d = anu_pkg::S_RMW_RD;
				else if (cmd_q.func == anu_pkg::FUNC_EDGE)
					state_d = anu_pkg::S_DONE;
				else
					state_d = anu_pkg::S_CHK;
			end
			anu_pkg::S_CHK: state_d = copy_go ? anu_pkg::S_DIV : anu_pkg::S_DONE;
			anu_pkg::S_COPY: begin
				lvl_we  = lvl_diff <= tol_q;
				state_d = anu_pkg::S_DONE;
			end
			anu_pkg::S_DONE: state_d = anu_pkg::S_IDLE;
			default: state_d = anu_pkg::S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= anu_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
			v_s1   <= 1'b0;
		end else begin
			if (state_q == anu_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
			done_q <= state_q == anu_pkg::S_DONE;
			v_s1   <= issuing;
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		if (issuing) j_q <= j_q + CW'(1);
		unique case (state_q)
			anu_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q <= cmd;
					res_q <= '0;
					a_q   <= LW'(cmd.node_a);
					row_q <= (cmd.func == anu_pkg::FUNC_COUNT) ? '0 : LW'(cmd.node_a);
					op_q  <= '0;
					disc_q <= '0;
					mode_q <= (cmd.func == anu_pkg::FUNC_COUNT) ? anu_pkg::M_DISC
						: anu_pkg::M_CNT;
					case (cmd.func) inside
						anu_pkg::FUNC_EDGE, anu_pkg::FUNC_LEVEL: res_q.status <= anu_pkg::ST_ACK;
						anu_pkg::FUNC_UPDATE: res_q.status <= anu_pkg::ST_ISOLATED;
						default: res_q.status <= anu_pkg::ST_COUNT;
					endcase
				end
			end
			anu_pkg::S_ROW_LAT: begin
				lvl_ref_q <= lvl_rdata;
				c_deg_q   <= '0;
				c_drop_q  <= '0;
				c_add_q   <= '0;
				j_q       <= (mode_q == anu_pkg::M_DISC) ? CW'(row_q) + CW'(1) : '0;
			end
			anu_pkg::S_SCAN: begin
				// Evaluate the node whose bit and level arrived this cycle.
				if (v_s1) begin
					case (mode_q)
						anu_pkg::M_CNT: begin
							if (ne_s1 && bit_s1) c_deg_q <= c_deg_q + CW'(1);
							if (ne_s1 && bit_s1 && same_s1 == drop_same)
								c_drop_q <= c_drop_q + CW'(1);
							if (ne_s1 && !bit_s1 && same_s1 == add_same)
								c_add_q <= c_add_q + CW'(1);
						end
						anu_pkg::M_FIND: begin
							if (ne_s1 && bit_s1 && same_s1 == drop_same) begin
								if (!found_d_q && seen_d_q == k_d_q) begin
									dn_q      <= j_s1[LW-1:0];
									found_d_q <= 1'b1;
								end
								seen_d_q <= seen_d_q + CW'(1);
							end
							if (ne_s1 && !bit_s1 && same_s1 == add_same) begin
								if (!found_a_q && seen_a_q == k_a_q) begin
									an_q      <= j_s1[LW-1:0];
									found_a_q <= 1'b1;
								end
								seen_a_q <= seen_a_q + CW'(1);
							end
						end
						anu_pkg::M_PEER: begin
							if (ne_s1 && bit_s1) begin
								if (!found_d_q && seen_d_q == k_d_q) begin
									peer_lv_q <= lvl_rdata;
									found_d_q <= 1'b1;
								end
								seen_d_q <= seen_d_q + CW'(1);
							end
						end
						default: begin
							if (bit_s1 && !same_s1 && disc_q != anu_pkg::DISC_MAX)
								disc_q <= disc_q + 15'd1;
						end
					endcase
				end
				if (scan_end && mode_q == anu_pkg::M_DISC) begin
					row_q <= row_q + LW'(1);
					res_q.discordant_count <= disc_q;
				end
			end
			anu_pkg::S_POST: begin
				res_q.new_level <= lvl_ref_q;
				if (c_deg_q != '0) res_q.status <= anu_pkg::ST_DONE;
				div_num_q <= cmd_q.pick_drop;
				div_den_q <= c_drop_q;
				div_rem_q <= '0;
				div_cnt_q <= '0;
				tgt_q     <= anu_pkg::D_DROP;
			end
			anu_pkg::S_DIV: begin
				// One remainder bit per cycle, then hand the result on.
				div_rem_q <= div_rem_d;
				div_num_q <= {div_num_q[30:0], 1'b0};
				div_cnt_q <= div_cnt_q + 5'd1;
				seen_d_q  <= '0;
				seen_a_q  <= '0;
				found_d_q <= 1'b0;
				found_a_q <= 1'b0;
				j_q       <= '0;
				if (div_cnt_q == 5'd31) begin
					case (tgt_q)
						anu_pkg::D_DROP: begin
							k_d_q     <= div_rem_d;
							div_num_q <= cmd_q.pick_add;
							div_den_q <= c_add_q;
							div_rem_q <= '0;
							tgt_q     <= anu_pkg::D_ADD;
						end
						anu_pkg::D_ADD: begin
							k_a_q  <= div_rem_d;
							mode_q <= anu_pkg::M_FIND;
						end
						default: begin
							k_d_q  <= div_rem_d;
							mode_q <= anu_pkg::M_PEER;
						end
					endcase
				end
			end
			anu_pkg::S_RMW_WR: begin
				op_q <= op_q + 2'd1;
				if (op_last && cmd_q.func != anu_pkg::FUNC_EDGE) begin
					res_q.rewired      <= 1'b1;
					res_q.dropped_node <= 8'(dn_q);
					res_q.added_node   <= 8'(an_q);
				end
			end
			anu_pkg::S_CHK: begin
				div_num_q <= cmd_q.pick_peer;
				div_den_q <= c_deg_q;
				div_rem_q <= '0;
				div_cnt_q <= '0;
				tgt_q     <= anu_pkg::D_PEER;
			end
			anu_pkg::S_COPY: begin
				if (lvl_diff <= tol_q) begin
					res_q.copied    <= 1'b1;
					res_q.new_level <= peer_lv_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rewire_q    <= anu_pkg::RST_REWIRE;
			copy_q      <= anu_pkg::RST_COPY;
			drop_same_q <= anu_pkg::RST_DROP_SAME;
			add_same_q  <= anu_pkg::RST_ADD_SAME;
			tol_q       <= anu_pkg::RST_TOL;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				anu_pkg::REG_REWIRE:    rewire_q    <= pwdata[15:0];
				anu_pkg::REG_COPY:      copy_q      <= pwdata[15:0];
				anu_pkg::REG_DROP_SAME: drop_same_q <= pwdata[15:0];
				anu_pkg::REG_ADD_SAME:  add_same_q  <= pwdata[15:0];
				anu_pkg::REG_TOL:       tol_q       <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[4:2])
			anu_pkg::REG_REWIRE:    prdata = {16'd0, rewire_q};
			anu_pkg::REG_COPY:      prdata = {16'd0, copy_q};
			anu_pkg::REG_DROP_SAME: prdata = {16'd0, drop_same_q};
			anu_pkg::REG_ADD_SAME:  prdata = {16'd0, add_same_q};
			anu_pkg::REG_TOL:       prdata = {26'd0, tol_q};
			default:                prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign busy   = state_q != anu_pkg::S_IDLE;
	assign done   = done_q;
	assign rsp    = res_q;

endmodule

/* sv/anu_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Adaptive network update port checker
// Checks the command and result ports of the step unit over time.
// ---------------------------------------------------------------------------
module anu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input anu_pkg::rsp_t rsp
);

	// An accepted command keeps the unit busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("unit not busy after an accepted command");

	// A result beat is shown only while the unit is free again.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// A result beat lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat held for more than one cycle");

	// Only count results carry a count.
	a_count_field: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != anu_pkg::ST_COUNT |-> rsp.discordant_count == '0)
		else $error("count field set on a non-count result");

	// Rewiring and copying are reported only for completed updates.
	a_update_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != anu_pkg::ST_DONE |-> !rsp.rewired && !rsp.copied)
		else $error("update flags set on a non-update result");

endmodule

bind adaptive_network_update_step_unit anu_checker u_anu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

/* dv/tb_adaptive_network_update_step_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Adaptive network update step unit testbench
// Drives load, update and count commands with bursty timing and checks every
// result beat against a cycle-free prediction of the graph and level state.
// The rewiring, copying, class and tolerance registers are changed between phases.
// ---------------------------------------------------------------------------
module tb_adaptive_network_update_step_unit;

	localparam int NN       = 256;
	localparam int NLEV     = 40;
	localparam int WDOG_MAX = 200000;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	anu_pkg::cmd_t cmd;
	logic          done;
	anu_pkg::rsp_t rsp;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [4:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	adaptive_network_update_step_unit #(.NODES(NN), .LEVELS(NLEV)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow of the graph, the levels and the registers.
	bit [NN-1:0] adj_row [NN];
	bit [5:0]    lvl_mem [NN];
	bit [15:0]   rewire_p, copy_p, drop_same_p, add_same_p;
	bit [5:0]    tol_lv;

	anu_pkg::rsp_t rsp_pending [$];
	int            mismatches;
	int            burst_left;
	int            win_base;
	int            idle_cycles;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Members of one class of node n: linked or not, same level or not.
	function automatic int class_count(int n, bit linked, bit same);
		int c;
		c = 0;
		for (int i = 0; i < NN; i++)
			if (i != n && adj_row[n][i] == linked && ((lvl_mem[i] == lvl_mem[n]) == same))
				c++;
		return c;
	endfunction

	function automatic int class_member(int n, bit linked, bit same, int k);
		int seen;
		seen = 0;
		for (int i = 0; i < NN; i++)
			if (i != n && adj_row[n][i] == linked && ((lvl_mem[i] == lvl_mem[n]) == same)) begin
				if (seen == k)
					return i;
				seen++;
			end
		return 0;
	endfunction

	function automatic void put_edge(int i, int j, bit v);
		adj_row[i][j] = v;
		adj_row[j][i] = v;
	endfunction

	// Works out the result of one command and moves the shadow state on.
	function automatic anu_pkg::rsp_t network_step(anu_pkg::cmd_t c);
		anu_pkg::rsp_t r;
		int a, b, deg, dc, ac, dn, an, peer, x, y, diff;
		bit ds, as_;
		r = '0;
		a = c.node_a;
		b = c.node_b;
		case (c.func)
			anu_pkg::FUNC_EDGE: begin
				r.status = anu_pkg::ST_ACK;
				if (a != b)
					put_edge(a, b, c.value[0]);
			end
			anu_pkg::FUNC_LEVEL: begin
				r.status = anu_pkg::ST_ACK;
				lvl_mem[a] = (c.value >= NLEV) ? 6'(NLEV - 1) : c.value;
			end
			anu_pkg::FUNC_COUNT: begin
				int cnt;
				cnt = 0;
				r.status = anu_pkg::ST_COUNT;
				for (int i = 0; i < NN; i++)
					for (int j = i + 1; j < NN; j++)
						if (adj_row[i][j] && lvl_mem[i] != lvl_mem[j])
							cnt++;
				r.discordant_count = (cnt > 32767) ? anu_pkg::DISC_MAX : 15'(cnt);
			end
			default: begin
				deg = class_count(a, 1'b1, 1'b1) + class_count(a, 1'b1, 1'b0);
				if (deg == 0) begin
					r.status = anu_pkg::ST_ISOLATED;
					r.new_level = lvl_mem[a];
				end else begin
					r.status = anu_pkg::ST_DONE;
					if (c.draw_rewire <= rewire_p) begin
						ds  = c.draw_drop_class <= drop_same_p;
						as_ = c.draw_add_class <= add_same_p;
						dc  = class_count(a, 1'b1, ds);
						ac  = class_count(a, 1'b0, as_);
						if (dc != 0 && ac != 0) begin
							dn = class_member(a, 1'b1, ds, int'(c.pick_drop % 32'(dc)));
							an = class_member(a, 1'b0, as_, int'(c.pick_add % 32'(ac)));
							put_edge(a, dn, 1'b0);
							put_edge(a, an, 1'b1);
							r.rewired      = 1'b1;
							r.dropped_node = 8'(dn);
							r.added_node   = 8'(an);
						end
					end
					if (c.draw_copy <= copy_p) begin
						deg = 0;
						for (int i = 0; i < NN; i++)
							if (i != a && adj_row[a][i])
								deg++;
						if (deg != 0) begin
							int k, seen;
							k = int'(c.pick_peer % 32'(deg));
							seen = 0;
							peer = 0;
							for (int i = 0; i < NN; i++)
								if (i != a && adj_row[a][i]) begin
									if (seen == k) begin
										peer = i;
										break;
									end
									seen++;
								end
							x = lvl_mem[a];
							y = lvl_mem[peer];
							diff = (x > y) ? x - y : y - x;
							if (diff <= tol_lv) begin
								lvl_mem[a] = 6'(y);
								r.copied = 1'b1;
							end
						end
					end
					r.new_level = lvl_mem[a];
				end
			end
		endcase
		return r;
	endfunction

	// Result checker: each strobed beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rsp_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result beat %p", rsp);
			end else begin
				anu_pkg::rsp_t e;
				e = rsp_pending.pop_front();
				if (rsp.status !== e.status || rsp.rewired !== e.rewired ||
				    rsp.dropped_node !== e.dropped_node || rsp.added_node !== e.added_node ||
				    rsp.copied !== e.copied || rsp.new_level !== e.new_level ||
				    rsp.discordant_count !== e.discordant_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result mismatch, expected %p, got %p", e, rsp);
				end
			end
		end
	end

	// Watchdog on cycles in which no beat moves.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Sends one command beat, with a random gap once a burst runs out.
	task automatic send_cmd(input anu_pkg::cmd_t c);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
		cmd   <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		rsp_pending.push_back(network_step(c));
	endtask

	// Stops sending and waits until every result has come back.
	task automatic drain;
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (rsp_pending.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			anu_pkg::REG_REWIRE:    rewire_p    = data[15:0];
			anu_pkg::REG_COPY:      copy_p      = data[15:0];
			anu_pkg::REG_DROP_SAME: drop_same_p = data[15:0];
			anu_pkg::REG_ADD_SAME:  add_same_p  = data[15:0];
			default:                tol_lv      = data[5:0];
		endcase
	endtask

	task automatic set_config(input logic [15:0] rw, cp, dsm, asm, input logic [5:0] tl);
		drain();
		reg_write(anu_pkg::REG_REWIRE, {16'h0, rw});
		reg_write(anu_pkg::REG_COPY, {16'h0, cp});
		reg_write(anu_pkg::REG_DROP_SAME, {16'h0, dsm});
		reg_write(anu_pkg::REG_ADD_SAME, {16'h0, asm});
		reg_write(anu_pkg::REG_TOL, {26'h0, tl});
	endtask

	function automatic anu_pkg::cmd_t make_cmd(logic [1:0] f, logic [7:0] a, logic [7:0] b,
	                                           logic [5:0] v);
		anu_pkg::cmd_t c;
		c.func            = f;
		c.node_a          = a;
		c.node_b          = b;
		c.value           = v;
		c.draw_rewire     = 16'($urandom);
		c.draw_drop_class = 16'($urandom);
		c.pick_drop       = $urandom;
		c.draw_add_class  = 16'($urandom);
		c.pick_add        = $urandom;
		c.draw_copy       = 16'($urandom);
		c.pick_peer       = $urandom;
		return c;
	endfunction

	// Node from the current working window, now and then from anywhere.
	function automatic logic [7:0] pick_node();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom);
		return 8'(win_base + $urandom_range(0, 15));
	endfunction

	// Extremes of the fields, self-loops, saturation, isolated and empty-class cases.
	task automatic test_directed;
		anu_pkg::cmd_t c;
		send_cmd(make_cmd(anu_pkg::FUNC_COUNT, 8'd0, 8'd0, 6'd0));
		send_cmd(make_cmd(anu_pkg::FUNC_UPDATE, 8'd7, 8'd0, 6'd0));
		send_cmd(make_cmd(anu_pkg::FUNC_EDGE, 8'd5, 8'd5, 6'd63));
		send_cmd(make_cmd(anu_pkg::FUNC_UPDATE, 8'd5, 8'd0, 6'd0));
		send_cmd(make_cmd(anu_pkg::FUNC_LEVEL, 8'd255, 8'd0, 6'd63));
		send_cmd(make_cmd(anu_pkg::FUNC_LEVEL, 8'd0, 8'd0, 6'd39));
		send_cmd(make_cmd(anu_pkg::FUNC_LEVEL, 8'd1, 8'd0, 6'd40));
		send_cmd(make_cmd(anu_pkg::FUNC_UPDATE, 8'd255, 8'd0, 6'd0));
		send_cmd(make_cmd(anu_pkg::FUNC_EDGE, 8'd0, 8'd255, 6'd1));
		send_cmd(make_cmd(anu_pkg::FUNC_EDGE, 8'd255, 8'd1, 6'd62));
		send_cmd(make_cmd(anu_pkg::FUNC_EDGE, 8'd0, 8'd1, 6'd1));
		// Rewire with all draws at their extremes.
		c = make_cmd(anu_pkg::FUNC_UPDATE, 8'd0, 8'hFF, 6'h3F);
		c.draw_rewire = 16'h0;
		c.draw_drop_class = 16'hFFFF;
		c.pick_drop = 32'hFFFF_FFFF;
		c.draw_add_class = 16'hFFFF;
		c.pick_add = 32'hFFFF_FFFF;
		c.draw_copy = 16'hFFFF;
		c.pick_peer = 32'hFFFF_FFFF;
		send_cmd(c);
		// Same-level drop class of node 255 holds only node 0; whether a link moves depends on the rewire draw.
		c = make_cmd(anu_pkg::FUNC_UPDATE, 8'd255, 8'd0, 6'd0);
		c.draw_drop_class = 16'h0;
		c.draw_copy = 16'h0;
		c.pick_drop = 32'h0;
		c.pick_add = 32'h0;
		c.pick_peer = 32'h0;
		send_cmd(c);
		send_cmd(make_cmd(anu_pkg::FUNC_EDGE, 8'd1, 8'd0, 6'd0));
		send_cmd(make_cmd(anu_pkg::FUNC_UPDATE, 8'd1, 8'd0, 6'd0));
		send_cmd(make_cmd(anu_pkg::FUNC_COUNT, 8'hFF, 8'hFF, 6'h3F));
		drain();
	endtask

	// Random phase: graph loads around a moving window, updates and rare counts.
	task automatic test_random(input int n_items);
		int kind;
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 39) == 0)
				win_base = $urandom_range(0, 255);
			kind = $urandom_range(0, 199);
			if (kind == 0)
				send_cmd(make_cmd(anu_pkg::FUNC_COUNT, 8'($urandom), 8'($urandom),
					6'($urandom)));
			else if (kind < 70)
				send_cmd(make_cmd(anu_pkg::FUNC_EDGE, pick_node(), pick_node(),
					6'($urandom)));
			else if (kind < 100)
				send_cmd(make_cmd(anu_pkg::FUNC_LEVEL, pick_node(), 8'($urandom),
					($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3))));
			else
				send_cmd(make_cmd(anu_pkg::FUNC_UPDATE, pick_node(), 8'($urandom),
					6'($urandom)));
		end
	endtask

	// Register settings across phases, extremes included.
	task automatic test_config_sweep;
		test_random(160);
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
		test_random(170);
		set_config(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 6'd2);
		test_random(160);
		set_config(16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 6'd0);
		test_random(170);
		set_config(16'hC000, 16'h4000, 16'hFFFF, 16'h0000, 6'd5);
		test_random(160);
		set_config(16'h0000, 16'h0000, 16'h8000, 16'h8000, 6'd1);
		test_random(120);
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		mismatches  = 0;
		burst_left  = 0;
		win_base    = 0;
		idle_cycles = 0;
		rewire_p    = anu_pkg::RST_REWIRE;
		copy_p      = anu_pkg::RST_COPY;
		drop_same_p = anu_pkg::RST_DROP_SAME;
		add_same_p  = anu_pkg::RST_ADD_SAME;
		tol_lv      = anu_pkg::RST_TOL;
		for (int i = 0; i < NN; i++) begin
			adj_row[i] = '0;
			lvl_mem[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_sweep();
		drain();
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
